// ===== design/assert_macros.svh =====
// assertion macros used by the checker file rif_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== design/rif_pkg.sv =====
// ----------------------------------------------------------------------------
// rif_pkg
// Types, constants and helpers shared by the integer radix formatter.
// ----------------------------------------------------------------------------
package rif_pkg;

    localparam int VALUE_WIDTH    = 64;
    localparam int MAX_PAD_DIGITS = 22;
    localparam int OCT_DIGITS     = (VALUE_WIDTH + 2) / 3;
    localparam int N_SLOTS        = (OCT_DIGITS > MAX_PAD_DIGITS) ? OCT_DIGITS : MAX_PAD_DIGITS;
    localparam int W_SLOT         = $clog2(N_SLOTS + 1);
    localparam int W_BITCNT       = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int W_MIN          = 5;

    localparam logic [1:0] CMD_SDEC = 2'd0;
    localparam logic [1:0] CMD_UDEC = 2'd1;
    localparam logic [1:0] CMD_HEX  = 2'd2;
    localparam logic [1:0] CMD_OCT  = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_O     = 8'h6f;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] value;
        logic [4:0]  min_digits;
        logic        omit_prefix;
        logic        uppercase;
    } t_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_res;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_dig_ctl;

    function automatic logic is_neg(t_req req);
        return (req.cmd == CMD_SDEC) && req.value[VALUE_WIDTH-1];
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER : CH_LOWER;
        if (d <= 4'd9) begin
            return CH_ZERO + {4'h0, d};
        end
        return base + {4'h0, d} - 8'd10;
    endfunction

endpackage

// ===== design/rif_digits.sv =====
// ----------------------------------------------------------------------------
// rif_digits
// Digit shift register: loads hex or octal digits straight from the value,
// or builds decimal digits by shift-and-add-3, one value bit per cycle;
// then shifts digits out, most significant first.
// ----------------------------------------------------------------------------
module rif_digits (
    input  logic              i_clk,
    input  rif_pkg::t_req     i_req,
    input  rif_pkg::t_dig_ctl i_ctl,
    output logic [3:0]        o_top
);
    import rif_pkg::*;

    localparam int W_DIG = 4 * N_SLOTS;

    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [VALUE_WIDTH-1:0] w_val, w_mag;
    logic [W_DIG-1:0]       r_slots, n_slots;
    logic [W_DIG-1:0]       w_ext, w_load, w_adj;

    assign w_val = i_req.value[VALUE_WIDTH-1:0];
    assign w_mag = is_neg(i_req) ? (~w_val + 1'b1) : w_val;
    assign w_ext = {{(W_DIG - VALUE_WIDTH){1'b0}}, w_val};

    always_comb begin
        w_load = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            unique case (i_req.cmd) inside
                CMD_HEX: w_load[4*i +: 4] = w_ext[4*i +: 4];
                CMD_OCT: w_load[4*i +: 4] = {1'b0, w_ext[3*i +: 3]};
                CMD_SDEC, CMD_UDEC: w_load[4*i +: 4] = 4'h0;
                default: w_load[4*i +: 4] = 4'h0;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < N_SLOTS; i++) begin
            w_adj[4*i +: 4] = (r_slots[4*i +: 4] >= 4'd5) ? (r_slots[4*i +: 4] + 4'd3)
                                                           : r_slots[4*i +: 4];
        end
    end

    always_comb begin
        n_bin   = r_bin;
        n_slots = r_slots;
        if (i_ctl.load) begin
            n_bin   = w_mag;
            n_slots = w_load;
        end else if (i_ctl.step) begin
            n_slots = {w_adj[W_DIG-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin   = {r_bin[VALUE_WIDTH-2:0], 1'b0};
        end else if (i_ctl.shift) begin
            n_slots = {r_slots[W_DIG-5:0], 4'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_slots <= n_slots;
    end

    assign o_top = r_slots[W_DIG-1 -: 4];

endmodule

// ===== design/rif_seq.sv =====
// ----------------------------------------------------------------------------
// rif_seq
// Sequencer: runs the decimal conversion, emits sign or prefix, then walks
// the digit positions, dropping leading zeros beyond the minimum count.
// ----------------------------------------------------------------------------
module rif_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rif_pkg::t_req     i_req,
    input  logic [3:0]        i_top,
    output logic              o_busy,
    output rif_pkg::t_dig_ctl o_ctl,
    output logic              o_strobe,
    output rif_pkg::t_res     o_res
);
    import rif_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CONV = 6'b000010,
        S_SIGN = 6'b000100,
        S_PRE0 = 6'b001000,
        S_PRE1 = 6'b010000,
        S_WALK = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [W_BITCNT-1:0]   r_bitcnt, n_bitcnt;
    logic [W_SLOT-1:0]     r_k, n_k;
    logic [W_SLOT-1:0]     r_min, n_min;
    logic                  r_neg, n_neg;
    logic                  r_hex, n_hex;
    logic                  r_upper, n_upper;
    logic                  r_started, n_started;
    logic                  r_strobe, n_strobe;
    t_res                  r_res, n_res;
    logic                  w_accept;
    logic                  w_emit;
    logic [W_SLOT-1:0]     w_min_sat;

    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_min_sat = (i_req.min_digits > W_MIN'(MAX_PAD_DIGITS)) ? W_SLOT'(MAX_PAD_DIGITS)
                                                                    : W_SLOT'(i_req.min_digits);
    assign w_emit    = r_started || (i_top != 4'h0) || (r_k < r_min) || (r_k == '0);

    always_comb begin
        n_state   = r_state;
        n_bitcnt  = r_bitcnt;
        n_k       = r_k;
        n_min     = r_min;
        n_neg     = r_neg;
        n_hex     = r_hex;
        n_upper   = r_upper;
        n_started = r_started;
        n_strobe  = 1'b0;
        n_res     = r_res;
        o_ctl     = '0;
        o_ctl.load = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_bitcnt  = W_BITCNT'(VALUE_WIDTH - 1);
                    n_k       = W_SLOT'(N_SLOTS - 1);
                    n_started = 1'b0;
                    n_neg     = is_neg(i_req);
                    n_hex     = (i_req.cmd == CMD_HEX);
                    n_upper   = i_req.uppercase;
                    if ((i_req.cmd == CMD_SDEC) || (i_req.cmd == CMD_UDEC)) begin
                        n_min   = W_SLOT'(1);
                        n_state = S_CONV;
                    end else begin
                        n_min   = w_min_sat;
                        n_state = i_req.omit_prefix ? S_WALK : S_PRE0;
                    end
                end
            end
            S_CONV: begin
                o_ctl.step = 1'b1;
                n_bitcnt   = r_bitcnt - 1'b1;
                if (r_bitcnt == '0) begin
                    n_state = r_neg ? S_SIGN : S_WALK;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_res    = '{out_char: CH_MINUS, last: 1'b0};
                n_state  = S_WALK;
            end
            S_PRE0: begin
                n_strobe = 1'b1;
                n_res    = '{out_char: CH_ZERO, last: 1'b0};
                n_state  = S_PRE1;
            end
            S_PRE1: begin
                n_strobe = 1'b1;
                n_res    = '{out_char: (r_hex ? CH_X : CH_O), last: 1'b0};
                n_state  = S_WALK;
            end
            S_WALK: begin
                o_ctl.shift = 1'b1;
                n_started   = r_started || w_emit;
                n_k         = r_k - 1'b1;
                if (w_emit) begin
                    n_strobe = 1'b1;
                    n_res    = '{out_char: digit_char(i_top, r_upper), last: (r_k == '0)};
                end
                if (r_k == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bitcnt  <= n_bitcnt;
        r_k       <= n_k;
        r_min     <= n_min;
        r_neg     <= n_neg;
        r_hex     <= n_hex;
        r_upper   <= n_upper;
        r_started <= n_started;
        r_res     <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ===== design/integer_radix_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_radix_formatter_top
// Formats a value as signed or unsigned decimal, hex or octal ASCII text.
// Decimal runs shift-and-add-3 in the digit register, one value bit per cycle,
// then an optional sign character and a walk over the digit positions, one
// digit position per cycle. Hex and octal skip the conversion: an optional
// two-character prefix, then the walk. One request at a time; the results
// cannot be stalled.
// Synchronous active-low reset returns to idle with no result pending.
// ----------------------------------------------------------------------------
module integer_radix_formatter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rif_pkg::t_req i_req,
    output logic          o_strobe,
    output rif_pkg::t_res o_res
);
    import rif_pkg::*;

    t_dig_ctl   w_ctl;
    logic [3:0] w_top;

    rif_digits u_digits (
        .i_clk (i_clk),
        .i_req (i_req),
        .i_ctl (w_ctl),
        .o_top (w_top)
    );

    rif_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_top    (w_top),
        .o_busy   (busy),
        .o_ctl    (w_ctl),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

// ===== design/rif_checker.sv =====
// ----------------------------------------------------------------------------
// rif_checker
// Port-level checks on the formatter's request and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rif_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input rif_pkg::t_res o_res
);
    import rif_pkg::*;

    `ASSERT_CLK(a_busy_after_start, (start && !busy) |=> busy, "no busy after request")
    `ASSERT_CLK(a_gap_after_last, (o_strobe && o_res.last) |=> !o_strobe, "result after last")
    `ASSERT_CLK(a_idle_quiet, (!busy && !o_strobe) |=> !o_strobe, "result while idle")
    `ASSERT_NEVER(a_idle_not_last, o_strobe && !busy && !o_res.last, "idle before last")

endmodule

bind integer_radix_formatter_top rif_checker u_rif_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer radix formatter. Requests are queued
// up front, then driven on the falling edge with random idle gaps that
// change by phase. Every accepted request is formatted by a local model into
// the characters it should produce, and each strobed character is checked
// against the oldest one still owed.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rif_pkg::*;

    localparam int MAX_TEXT_CHARS = 24;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        t_req        req;
        int unsigned idle_pct;
        bit          drain_first;
    } t_pending_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_strobe;
    t_res o_res;

    t_pending_req pending_reqs[$];
    t_res         owed_chars[$];
    logic         req_taken = 1'b0;
    int           mismatch_count = 0;
    int           chars_checked = 0;
    int           reqs_by_cmd[4] = '{0, 0, 0, 0};
    int           drain_pauses = 0;
    int unsigned  gap_cycles = 0;
    int unsigned  cur_idle_pct = 0;

    integer_radix_formatter_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] error: %s", $time, what);
        mismatch_count++;
    endtask

    // builds the characters a request should produce and queues them
    function automatic void queue_formatted_text(input t_req req);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [7:0]  text[$];
        logic [7:0]  digs[$];
        logic [3:0]  d;
        int unsigned radix;
        int unsigned min_d;
        t_res        r;
        mask  = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
        mag   = req.value & mask;
        min_d = (req.min_digits > MAX_PAD_DIGITS) ? MAX_PAD_DIGITS : req.min_digits;
        if (req.cmd == CMD_SDEC || req.cmd == CMD_UDEC) begin
            radix = 10;
            if (req.cmd == CMD_SDEC && mag[VALUE_WIDTH-1]) begin
                text.push_back(CH_MINUS);
                mag = (~mag + 64'd1) & mask;
            end
        end else begin
            radix = (req.cmd == CMD_HEX) ? 16 : 8;
            if (!req.omit_prefix) begin
                text.push_back(CH_ZERO);
                text.push_back((req.cmd == CMD_HEX) ? CH_X : CH_O);
            end
        end
        do begin
            d = 4'(mag % radix);
            if (d <= 4'd9) begin
                digs.push_front(8'(CH_ZERO + d));
            end else begin
                digs.push_front(8'((req.uppercase ? CH_UPPER : CH_LOWER) + d - 8'd10));
            end
            mag = mag / radix;
        end while (mag != 64'd0);
        if (radix != 10) begin
            for (int i = digs.size(); i < int'(min_d); i++) begin
                text.push_back(CH_ZERO);
            end
        end
        foreach (digs[i]) begin
            if (text.size() < MAX_TEXT_CHARS) begin
                text.push_back(digs[i]);
            end
        end
        foreach (text[i]) begin
            r.out_char = text[i];
            r.last     = (i == text.size() - 1);
            owed_chars.push_back(r);
        end
    endfunction

    task automatic add_request(input logic [1:0] cmd, input logic [63:0] value,
                               input logic [4:0] min_d, input bit no_pfx, input bit upper,
                               input int unsigned pct, input bit drain);
        t_pending_req p;
        p.req.cmd         = cmd;
        p.req.value       = value;
        p.req.min_digits  = min_d;
        p.req.omit_prefix = no_pfx;
        p.req.uppercase   = upper;
        p.idle_pct        = pct;
        p.drain_first     = drain;
        pending_reqs.push_back(p);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (req_taken && $urandom_range(99) < cur_idle_pct) begin
                gap_cycles = $urandom_range(1, 100);
            end
            if (gap_cycles > 0) begin
                gap_cycles--;
                start <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain_first && owed_chars.size() > 0)) begin
                if (pending_reqs[0].drain_first) begin
                    drain_pauses++;
                end
                i_req        <= pending_reqs[0].req;
                cur_idle_pct  = pending_reqs[0].idle_pct;
                void'(pending_reqs.pop_front());
                start        <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (owed_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 8'h%02h last %0b",
                                              o_res.out_char, o_res.last));
                end else begin
                    want = owed_chars.pop_front();
                    chars_checked++;
                    if (o_res.out_char !== want.out_char) begin
                        report_mismatch($sformatf("char 8'h%02h, wanted 8'h%02h",
                                                  o_res.out_char, want.out_char));
                    end
                    if (o_res.last !== want.last) begin
                        report_mismatch($sformatf("last %0b, wanted %0b",
                                                  o_res.last, want.last));
                    end
                end
            end
            if (start && !busy) begin
                queue_formatted_text(i_req);
                reqs_by_cmd[i_req.cmd]++;
            end
            req_taken <= start && !busy;
        end else begin
            req_taken <= 1'b0;
        end
    end

    initial begin
        int unsigned phase_pct[3];
        logic [63:0] v;
        logic [1:0]  cmd;

        phase_pct = '{0, 66, 15};

        // directed requests
        add_request(CMD_SDEC, 64'd0, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_SDEC, '1, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_SDEC, 64'h8000_0000_0000_0000, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_SDEC, 64'h7fff_ffff_ffff_ffff, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_SDEC, 64'd123, 5'd20, 1'b1, 1'b1, 0, 1'b0);
        add_request(CMD_UDEC, 64'd0, 5'd31, 1'b0, 1'b1, 0, 1'b0);
        add_request(CMD_UDEC, '1, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_UDEC, 64'd9999999999999999999, 5'd0, 1'b1, 1'b0, 0, 1'b0);
        add_request(CMD_UDEC, 64'h8000_0000_0000_0000, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_HEX, 64'd0, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_HEX, 64'd0, 5'd1, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_HEX, 64'd0, 5'd22, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_HEX, '1, 5'd0, 1'b0, 1'b1, 0, 1'b0);
        add_request(CMD_HEX, '1, 5'd16, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_HEX, 64'hfedc_ba98_7654_3210, 5'd31, 1'b0, 1'b1, 0, 1'b0);
        add_request(CMD_HEX, 64'habcdef, 5'd8, 1'b1, 1'b1, 0, 1'b0);
        add_request(CMD_HEX, 64'habcdef, 5'd3, 1'b1, 1'b0, 0, 1'b0);
        add_request(CMD_OCT, 64'd0, 5'd0, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_OCT, '1, 5'd31, 1'b0, 1'b0, 0, 1'b0);
        add_request(CMD_OCT, 64'd8, 5'd3, 1'b1, 1'b0, 0, 1'b0);
        add_request(CMD_OCT, 64'h8000_0000_0000_0000, 5'd23, 1'b1, 1'b1, 0, 1'b0);
        add_request(CMD_OCT, 64'o1234567, 5'd2, 1'b0, 1'b0, 0, 1'b0);

        // random requests in idling phases
        foreach (phase_pct[ph]) begin
            for (int n = 0; n < 130; n++) begin
                cmd = 2'($urandom_range(3));
                case ($urandom_range(3))
                    0: v = {$urandom, $urandom};
                    1: v = {$urandom, $urandom} >> $urandom_range(63);
                    2: v = -({$urandom, $urandom} >> $urandom_range(63));
                    default: v = 64'($urandom_range(20));
                endcase
                add_request(cmd, v, 5'($urandom_range(31)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), phase_pct[ph], n == 0);
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_reqs.size() > 0 || start || owed_chars.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d signed dec, %0d unsigned dec, %0d hex, %0d octal",
                 reqs_by_cmd[0], reqs_by_cmd[1], reqs_by_cmd[2], reqs_by_cmd[3]);
        $display("%0d characters checked, %0d pauses for an empty pipe, %0d errors",
                 chars_checked, drain_pauses, mismatch_count);
        if (mismatch_count == 0 && owed_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d chars still owed", owed_chars.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
